>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, held off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication check: when the antecedent holds the consequent must hold too.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

>>> hdl/bpps_pkg.sv
// Types and constants of the button press pulse sequencer.
package bpps_pkg;

  localparam int CNT_W  = 16;
  localparam int CIDX_W = 3;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_CLICK = 2'd1,
    FUNC_HOLD  = 2'd2,
    FUNC_RESET = 2'd3
  } func_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DISABLED = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  localparam logic [CIDX_W-1:0] REG_UNIT_ENABLE   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_LAMP_PRESENT  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_SHORT_TICKS   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_LONG_TICKS    = 3'd3;
  localparam logic [CIDX_W-1:0] REG_SETTLE_TICKS  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_PRESS_HIGH    = 3'd5;
  localparam logic [CIDX_W-1:0] REG_LAMP_ON_HIGH  = 3'd6;

  localparam logic [CNT_W-1:0] SHORT_TICKS_RST  = 16'd200;
  localparam logic [CNT_W-1:0] LONG_TICKS_RST   = 16'd5000;
  localparam logic [CNT_W-1:0] SETTLE_TICKS_RST = 16'd150;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_PRESS  = 3'b010,
    PH_SETTLE = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0] func;
    logic       lamp_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] request_status;
    logic       power_line;
    logic       reset_line;
    logic       lines_driven;
    logic       lamp_sensed;
    logic       target_powered;
    logic       busy_res;
  } out_item_t;

  typedef struct packed {
    logic             unit_enable;
    logic             lamp_present;
    logic [CNT_W-1:0] short_press_ticks;
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] settle_ticks;
    logic             press_level_high;
    logic             lamp_on_level_high;
  } cfg_t;

  typedef struct packed {
    logic flush;
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic nonempty_nxt;
  } fifo_stat_t;

endpackage

>>> hdl/bpps_cfg_regs.sv
// Configuration register file of the sequencer.
module bpps_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bpps_pkg::CIDX_W-1:0] cfg_index,
  input  logic [bpps_pkg::CNT_W-1:0]  cfg_wdata,
  output bpps_pkg::cfg_t             cfg
);
  import bpps_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_enable        <= 1'b0;
      cfg_r.lamp_present       <= 1'b0;
      cfg_r.short_press_ticks  <= SHORT_TICKS_RST;
      cfg_r.long_press_ticks   <= LONG_TICKS_RST;
      cfg_r.settle_ticks       <= SETTLE_TICKS_RST;
      cfg_r.press_level_high   <= 1'b0;
      cfg_r.lamp_on_level_high <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UNIT_ENABLE:  cfg_r.unit_enable        <= cfg_wdata[0];
        REG_LAMP_PRESENT: cfg_r.lamp_present       <= cfg_wdata[0];
        REG_SHORT_TICKS:  cfg_r.short_press_ticks  <= cfg_wdata;
        REG_LONG_TICKS:   cfg_r.long_press_ticks   <= cfg_wdata;
        REG_SETTLE_TICKS: cfg_r.settle_ticks       <= cfg_wdata;
        REG_PRESS_HIGH:   cfg_r.press_level_high   <= cfg_wdata[0];
        REG_LAMP_ON_HIGH: cfg_r.lamp_on_level_high <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/bpps_cmd_fifo.sv
// Shifting command queue: the oldest command always sits in entry 0.
module bpps_cmd_fifo #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  bpps_pkg::fifo_ctl_t    ctl,
  input  logic [1:0]             wdata,
  output bpps_pkg::fifo_stat_t   stat,
  output logic [1:0]             head
);
  import bpps_pkg::*;

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [1:0]    entry_r   [FIFO_DEPTH];
  logic [1:0]    entry_nxt [FIFO_DEPTH];
  logic [CW-1:0] count_r, count_nxt, cnt0, cnt0_m1;

  assign cnt0    = ctl.flush ? '0 : count_r;
  assign cnt0_m1 = cnt0 - CW'(1);

  always_comb begin
    count_nxt = cnt0;
    if (ctl.push && !ctl.pop) begin
      count_nxt = cnt0 + CW'(1);
    end else if (ctl.pop && !ctl.push) begin
      count_nxt = cnt0_m1;
    end
  end

  // Each entry either shifts down on a pop or takes the new command at the tail.
  always_comb begin
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      entry_nxt[i] = entry_r[i];
      if (ctl.pop) begin
        if (ctl.push && cnt0_m1 == CW'(i)) begin
          entry_nxt[i] = wdata;
        end else if (i < FIFO_DEPTH - 1) begin
          entry_nxt[i] = entry_r[i + 1];
        end
      end else if (ctl.push && cnt0 == CW'(i)) begin
        entry_nxt[i] = wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (step) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < FIFO_DEPTH; i++) begin
        entry_r[i] <= entry_nxt[i];
      end
    end
  end

  assign stat.empty        = (count_r == '0);
  assign stat.full         = (count_r >= CW'(FIFO_DEPTH));
  assign stat.nonempty_nxt = (count_nxt != '0);
  assign head              = entry_r[0];

endmodule

>>> hdl/bpps_seq.sv
// Press sequencer: phase, countdown and line selection, plus the result beat.
module bpps_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  bpps_pkg::in_item_t   item,
  input  bpps_pkg::cfg_t       cfg,
  input  bpps_pkg::fifo_stat_t fstat,
  input  logic [1:0]           fhead,
  output bpps_pkg::fifo_ctl_t  fctl,
  output bpps_pkg::out_item_t  result
);
  import bpps_pkg::*;

  phase_t           phase_r, phase_nxt, ph0, ph1;
  logic [CNT_W-1:0] cd_r, cd_nxt, cd0, cd1;
  logic             pr_r, pr_nxt, pr0;
  logic             en, is_tick, empty0, push, pop, done;
  logic [1:0]       cmd, status;
  logic             idle_lvl, pwr, rst;

  assign en      = cfg.unit_enable;
  assign is_tick = (item.func == FUNC_TICK);
  assign ph0     = en ? phase_r : PH_IDLE;
  assign cd0     = en ? cd_r : '0;
  assign pr0     = en ? pr_r : 1'b0;
  assign empty0  = !en || fstat.empty;
  assign done    = (cd0 == '0) || (cd0 == CNT_W'(1));

  // Tick: count the running phase down and advance it when it expires.
  always_comb begin
    ph1 = ph0;
    cd1 = cd0;
    if (is_tick && ph0 != PH_IDLE) begin
      if (done) begin
        if (ph0 == PH_PRESS) begin
          ph1 = PH_SETTLE;
          cd1 = cfg.settle_ticks;
        end else begin
          ph1 = PH_IDLE;
          cd1 = '0;
        end
      end else begin
        cd1 = cd0 - CNT_W'(1);
      end
    end
  end

  always_comb begin
    status = STATUS_OK;
    push   = 1'b0;
    if (!is_tick) begin
      if (!en) begin
        status = STATUS_DISABLED;
      end else if (fstat.full) begin
        status = STATUS_FULL;
      end else begin
        push = 1'b1;
      end
    end
  end

  // Pop when idle; a request landing in an empty queue is popped straight away.
  assign pop = (ph1 == PH_IDLE) && (!empty0 || push);
  assign cmd = empty0 ? item.func : fhead;

  always_comb begin
    phase_nxt = ph1;
    cd_nxt    = cd1;
    pr_nxt    = pr0;
    if (pop) begin
      phase_nxt = PH_PRESS;
      case (cmd)
        FUNC_HOLD: begin
          pr_nxt = 1'b0;
          cd_nxt = cfg.long_press_ticks;
        end
        FUNC_RESET: begin
          pr_nxt = 1'b1;
          cd_nxt = cfg.short_press_ticks;
        end
        default: begin
          pr_nxt = 1'b0;
          cd_nxt = cfg.short_press_ticks;
        end
      endcase
    end
  end

  assign fctl.flush = !en;
  assign fctl.push  = push;
  assign fctl.pop   = pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cd_r    <= '0;
      pr_r    <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cd_r    <= cd_nxt;
      pr_r    <= pr_nxt;
    end
  end

  always_comb begin
    idle_lvl = !cfg.press_level_high;
    pwr      = 1'b0;
    rst      = 1'b0;
    if (en) begin
      pwr = idle_lvl;
      rst = idle_lvl;
      if (phase_nxt == PH_PRESS) begin
        if (pr_nxt) begin
          rst = cfg.press_level_high;
        end else begin
          pwr = cfg.press_level_high;
        end
      end
    end
  end

  assign result.request_status = status;
  assign result.power_line     = pwr;
  assign result.reset_line     = rst;
  assign result.lines_driven   = en;
  assign result.lamp_sensed    = en && cfg.lamp_present;
  assign result.target_powered = en && cfg.lamp_present &&
                                 (cfg.lamp_on_level_high ? item.lamp_level : !item.lamp_level);
  assign result.busy_res       = (phase_nxt != PH_IDLE) || fstat.nonempty_nxt;

endmodule

>>> hdl/button_press_pulse_sequencer_core.sv
// An accepted beat is held in the input register and then in the result register.
// Throughput: one beat per cycle; the input register loads whenever it is empty or the
// result register advances, and the result register advances whenever it is empty or its
// beat is being taken.
// Reset (synchronous, rst_n low): valids clear, queue empties, sequencer goes idle,
// configuration returns to its reset values; there is no clearing pass.
module button_press_pulse_sequencer_core #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bpps_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bpps_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [bpps_pkg::CIDX_W-1:0] cfg_index,
  input  logic [bpps_pkg::CNT_W-1:0]  cfg_wdata
);
  import bpps_pkg::*;

  cfg_t       cfg;
  fifo_ctl_t  fctl;
  fifo_stat_t fstat;
  logic [1:0] fhead;
  in_item_t   s1_item_r;
  logic       s1_valid_r;
  out_item_t  result, out_item_r;
  logic       out_valid_r;
  logic       out_adv, step;

  assign out_adv  = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && out_adv;
  assign in_stall = s1_valid_r && !out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
    if (step) begin
      out_item_r <= result;
    end
  end

  bpps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bpps_cmd_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .ctl   (fctl),
    .wdata (s1_item_r.func),
    .stat  (fstat),
    .head  (fhead)
  );

  bpps_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (s1_item_r),
    .cfg    (cfg),
    .fstat  (fstat),
    .fhead  (fhead),
    .fctl   (fctl),
    .result (result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

>>> hdl/bpps_checker.sv
// Port-level checker for the sequencer core and its bind.
`include "assert_macros.svh"

module bpps_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input bpps_pkg::out_item_t         out_data
);
  import bpps_pkg::*;

  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data),
    "stalled result beat changed")
  `ASSERT_IMPL(a_released, out_valid && !out_data.lines_driven,
    !out_data.power_line && !out_data.reset_line && !out_data.busy_res,
    "released lines not quiet")
  `ASSERT_IMPL(a_full_busy, out_valid && out_data.request_status == STATUS_FULL,
    out_data.busy_res && out_data.lines_driven, "full queue without busy sequencer")
  `ASSERT_IMPL(a_disabled, out_valid && out_data.request_status == STATUS_DISABLED,
    !out_data.lines_driven && !out_data.lamp_sensed, "disabled status with unit enabled")

endmodule

bind button_press_pulse_sequencer_core bpps_checker u_bpps_checker (.*);

>>> tb/button_press_pulse_sequencer_core_tb.sv
// Self-checking testbench for the button press pulse sequencer core.
`timescale 1ns / 1ps
module button_press_pulse_sequencer_core_tb;
  import bpps_pkg::*;

  localparam int QDEPTH       = 4;
  localparam int IDLE_PCT     = 19;
  localparam int HANG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 6;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]  cfg_wdata = '0;

  button_press_pulse_sequencer_core #(.FIFO_DEPTH(QDEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Predictor state: register copy plus the sequencer's queue and countdown.
  cfg_t             model_cfg;
  func_t            cmd_fifo [QDEPTH];
  logic [1:0]       cmd_head;
  logic [2:0]       cmd_count;
  phase_t           seq_phase;
  logic [CNT_W-1:0] seq_count;
  logic             sel_reset;

  in_item_t  pending_items[$];
  out_item_t expected_outs[$];
  int        n_queued    = 0;
  int        n_accepted  = 0;
  int        n_fail      = 0;
  int        hang_cycles = 0;
  int        cyc         = 0;
  logic      in_beat_done = 1'b0;
  logic      steady;

  // No idling on either side inside this window.
  assign steady = (cyc >= 600) && (cyc < 1100);

  function automatic out_item_t sequencer_step(input in_item_t it);
    out_item_t  r;
    func_t      f;
    func_t      cmd;
    logic       done;
    logic [1:0] slot;
    r = '0;
    f = func_t'(it.func);
    if (!model_cfg.unit_enable) begin
      cmd_count = '0;
      seq_phase = PH_IDLE;
      seq_count = '0;
      sel_reset = 1'b0;
    end
    if (f == FUNC_TICK) begin
      if (seq_phase != PH_IDLE) begin
        if (seq_count == '0) begin
          done = 1'b1;
        end else begin
          seq_count = seq_count - 1'b1;
          done = (seq_count == '0);
        end
        if (done) begin
          if (seq_phase == PH_PRESS) begin
            seq_phase = PH_SETTLE;
            seq_count = model_cfg.settle_ticks;
          end else begin
            seq_phase = PH_IDLE;
            seq_count = '0;
          end
        end
      end
      r.request_status = STATUS_OK;
    end else if (!model_cfg.unit_enable) begin
      r.request_status = STATUS_DISABLED;
    end else if (cmd_count >= QDEPTH) begin
      r.request_status = STATUS_FULL;
    end else begin
      slot = cmd_head + cmd_count[1:0];
      cmd_fifo[slot] = f;
      cmd_count = cmd_count + 1'b1;
      r.request_status = STATUS_OK;
    end
    // Pop the next command once the sequencer is idle.
    if (seq_phase == PH_IDLE && cmd_count != '0) begin
      cmd = cmd_fifo[cmd_head];
      cmd_head = cmd_head + 1'b1;
      cmd_count = cmd_count - 1'b1;
      seq_phase = PH_PRESS;
      sel_reset = (cmd == FUNC_RESET);
      seq_count = (cmd == FUNC_HOLD) ? model_cfg.long_press_ticks
                                     : model_cfg.short_press_ticks;
    end
    if (model_cfg.unit_enable) begin
      r.power_line = ~model_cfg.press_level_high;
      r.reset_line = ~model_cfg.press_level_high;
      if (seq_phase == PH_PRESS) begin
        if (sel_reset) begin
          r.reset_line = model_cfg.press_level_high;
        end else begin
          r.power_line = model_cfg.press_level_high;
        end
      end
    end
    r.lines_driven = model_cfg.unit_enable;
    r.lamp_sensed  = model_cfg.unit_enable & model_cfg.lamp_present;
    if (r.lamp_sensed) begin
      r.target_powered = model_cfg.lamp_on_level_high ? it.lamp_level : ~it.lamp_level;
    end
    r.busy_res = (seq_phase != PH_IDLE) || (cmd_count != '0);
    return r;
  endfunction

  // Input driver: hold a beat until taken, idle at random otherwise.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat_done) begin
      if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  // Monitor: check result beats, predict on input beats, watch for a hang.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      in_beat_done <= 1'b0;
    end else begin
      cyc = cyc + 1;
      if (out_valid && !out_stall) begin
        if (expected_outs.size() == 0) begin
          if (n_fail < 10) begin
            $display("%0t: unexpected result beat %b", $time, out_data);
          end
          n_fail = n_fail + 1;
        end else begin
          want = expected_outs.pop_front();
          if (out_data.request_status !== want.request_status ||
              out_data.power_line     !== want.power_line     ||
              out_data.reset_line     !== want.reset_line     ||
              out_data.lines_driven   !== want.lines_driven   ||
              out_data.lamp_sensed    !== want.lamp_sensed    ||
              out_data.target_powered !== want.target_powered ||
              out_data.busy_res       !== want.busy_res) begin
            if (n_fail < 10) begin
              $display("%0t: mismatch status/pwr/rst/drv/sense/on/busy exp %0d %b %b %b %b %b %b",
                       $time, want.request_status, want.power_line, want.reset_line,
                       want.lines_driven, want.lamp_sensed, want.target_powered,
                       want.busy_res);
              $display("%0t:                                      got %0d %b %b %b %b %b %b",
                       $time, out_data.request_status, out_data.power_line,
                       out_data.reset_line, out_data.lines_driven, out_data.lamp_sensed,
                       out_data.target_powered, out_data.busy_res);
            end
            n_fail = n_fail + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_outs.push_back(sequencer_step(in_data));
        n_accepted = n_accepted + 1;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        hang_cycles = 0;
      end else begin
        hang_cycles = hang_cycles + 1;
      end
      in_beat_done <= in_valid && !in_stall;
      if (hang_cycles >= HANG_LIMIT) begin
        $display("FAIL button_press_pulse_sequencer_core");
        $finish;
      end
    end
  end

  task automatic queue_item(input func_t f, input logic lamp);
    in_item_t it;
    it.func       = f;
    it.lamp_level = lamp;
    pending_items.push_back(it);
    n_queued = n_queued + 1;
  endtask

  task automatic queue_random(input int n, input int tick_pct);
    func_t f;
    repeat (n) begin
      if ($urandom_range(99) < tick_pct) begin
        f = FUNC_TICK;
      end else begin
        f = func_t'($urandom_range(FUNC_RESET, FUNC_CLICK));
      end
      queue_item(f, 1'($urandom_range(1, 0)));
    end
  endtask

  // Wait until every beat is taken and answered, then let the pipeline settle.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (n_accepted != n_queued || expected_outs.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_UNIT_ENABLE:  model_cfg.unit_enable        = val[0];
      REG_LAMP_PRESENT: model_cfg.lamp_present       = val[0];
      REG_SHORT_TICKS:  model_cfg.short_press_ticks  = val;
      REG_LONG_TICKS:   model_cfg.long_press_ticks   = val;
      REG_SETTLE_TICKS: model_cfg.settle_ticks       = val;
      REG_PRESS_HIGH:   model_cfg.press_level_high   = val[0];
      REG_LAMP_ON_HIGH: model_cfg.lamp_on_level_high = val[0];
      default: ;
    endcase
  endtask

  task automatic load_setup(input logic en, input logic lp, input logic [CNT_W-1:0] sh,
                            input logic [CNT_W-1:0] lg, input logic [CNT_W-1:0] st,
                            input logic ph, input logic lh);
    write_reg(REG_UNIT_ENABLE, CNT_W'(en));
    write_reg(REG_LAMP_PRESENT, CNT_W'(lp));
    write_reg(REG_SHORT_TICKS, sh);
    write_reg(REG_LONG_TICKS, lg);
    write_reg(REG_SETTLE_TICKS, st);
    write_reg(REG_PRESS_HIGH, CNT_W'(ph));
    write_reg(REG_LAMP_ON_HIGH, CNT_W'(lh));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    model_cfg.unit_enable        = 1'b0;
    model_cfg.lamp_present       = 1'b0;
    model_cfg.short_press_ticks  = SHORT_TICKS_RST;
    model_cfg.long_press_ticks   = LONG_TICKS_RST;
    model_cfg.settle_ticks       = SETTLE_TICKS_RST;
    model_cfg.press_level_high   = 1'b0;
    model_cfg.lamp_on_level_high = 1'b0;
    cmd_head  = '0;
    cmd_count = '0;
    seq_phase = PH_IDLE;
    seq_count = '0;
    sel_reset = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration: unit disabled, every request refused.
    queue_item(FUNC_CLICK, 1'b1);
    queue_item(FUNC_HOLD, 1'b0);
    queue_item(FUNC_RESET, 1'b1);
    queue_item(FUNC_TICK, 1'b0);
    wait_drained();

    // Fill the queue past full, then tick through with a zero settle gap.
    load_setup(1'b1, 1'b1, 16'd1, 16'd2, 16'd0, 1'b1, 1'b0);
    queue_item(FUNC_CLICK, 1'b0);
    queue_item(FUNC_HOLD, 1'b1);
    queue_item(FUNC_RESET, 1'b0);
    queue_item(FUNC_CLICK, 1'b1);
    queue_item(FUNC_CLICK, 1'b0);
    queue_item(FUNC_CLICK, 1'b1);
    repeat (6) begin
      queue_item(FUNC_TICK, 1'b0);
      queue_item(FUNC_TICK, 1'b1);
    end
    wait_drained();

    load_setup(1'b1, 1'b1, 16'd2, 16'd5, 16'd1, 1'b0, 1'b1);
    queue_random(200, 55);
    wait_drained();

    // Zero counts: every phase ends on the next tick.
    load_setup(1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
    queue_random(150, 50);
    wait_drained();

    load_setup(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    queue_random(80, 40);
    wait_drained();

    // Disable with a press running and a full queue: flush on the next beat.
    load_setup(1'b0, 1'b1, 16'd3, 16'd3, 16'd3, 1'b1, 1'b1);
    queue_random(80, 50);
    wait_drained();

    load_setup(1'b1, 1'b1, 16'd1, 16'd4, 16'd2, 1'b1, 1'b1);
    queue_random(200, 55);
    wait_drained();

    repeat (3) begin
      load_setup(1'b1, 1'($urandom_range(1, 0)), CNT_W'($urandom_range(6, 0)),
                 CNT_W'($urandom_range(10, 0)), CNT_W'($urandom_range(4, 0)),
                 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
      queue_random(110, 55);
      wait_drained();
    end

    if (n_fail == 0 && expected_outs.size() == 0) begin
      $display("PASS button_press_pulse_sequencer_core");
    end else begin
      $display("FAIL button_press_pulse_sequencer_core");
    end
    $finish;
  end

endmodule
